// ===== rtl/core/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 3;

  localparam logic [BYTE_W-1:0]  START_BYTE     = 8'hAA;
  localparam logic [15:0]        HDR_TRL_BYTES  = 16'd16;
  localparam logic [15:0]        LENGTH_LIMIT   = 16'd1007;
  localparam logic [COUNT_W-1:0] RESERVED_BYTES = 3'd5;
  localparam logic [COUNT_W-1:0] CHECK_BYTES    = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_SKIP       = 3'd1,
    PH_LENGTH     = 3'd2,
    PH_RESERVED   = 3'd3,
    PH_CHECK      = 3'd4,
    PH_PAYLOAD    = 3'd5,
    PH_TRAILER    = 3'd6
  } sfd_phase_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] payload_index;
    logic [BYTE_W-1:0]  payload_byte;
    logic               last_payload;
    logic [BYTE_W-1:0]  command_id;
    logic [INDEX_W-1:0] payload_length;
  } sfd_result_t;

  typedef struct packed {
    logic        push;
    sfd_result_t data;
  } sfd_push_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfd_if.sv =====
`default_nettype none

interface sfd_rx_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  import sfd_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] payload_index;
  logic [BYTE_W-1:0]  payload_byte;
  logic               last_payload;
  logic [BYTE_W-1:0]  command_id;
  logic [INDEX_W-1:0] payload_length;
  modport source (output valid, output kind, output payload_index, output payload_byte,
                  output last_payload, output command_id, output payload_length,
                  input ready);
  modport sink (input valid, input kind, input payload_index, input payload_byte,
                input last_payload, input command_id, input payload_length,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfd_parser.sv =====
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output sfd_push_t              result
);

  sfd_phase_t         phase, phase_next;
  logic [COUNT_W-1:0] field_count, field_count_next;
  logic [INDEX_W-1:0] remaining, remaining_next;
  logic [INDEX_W-1:0] frame_length, frame_length_next;
  logic               length_bad, length_bad_next;
  logic [BYTE_W-1:0]  command_reg, command_reg_next;

  logic [15:0]        len16;
  logic               len_ok;
  logic [COUNT_W-1:0] fc_inc;
  logic [INDEX_W-1:0] idx;
  logic [INDEX_W-1:0] rem_dec;

  // Length byte counts whole-frame words; the header and trailer take 16 bytes.
  assign len16   = {6'd0, rx_byte, 2'b00} - HDR_TRL_BYTES;
  assign len_ok  = (len16 != 16'd0) && (len16 < LENGTH_LIMIT);
  assign fc_inc  = field_count + 3'd1;
  assign idx     = frame_length - remaining;
  assign rem_dec = remaining - 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_START;
      field_count  <= '0;
      remaining    <= '0;
      frame_length <= '0;
      length_bad   <= 1'b0;
      command_reg  <= '0;
    end else begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      remaining    <= remaining_next;
      frame_length <= frame_length_next;
      length_bad   <= length_bad_next;
      command_reg  <= command_reg_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    remaining_next    = remaining;
    frame_length_next = frame_length;
    length_bad_next   = length_bad;
    command_reg_next  = command_reg;
    result            = '0;
    if (accept) begin
      unique case (phase)
        PH_WAIT_START: begin
          if (rx_byte == START_BYTE) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          phase_next = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_bad_next   = ~len_ok;
          frame_length_next = len_ok ? len16[INDEX_W-1:0] : '0;
          remaining_next    = len_ok ? len16[INDEX_W-1:0] : '0;
          field_count_next  = '0;
          phase_next        = PH_RESERVED;
        end
        PH_RESERVED: begin
          if (fc_inc == RESERVED_BYTES) begin
            field_count_next = '0;
            phase_next       = PH_CHECK;
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_CHECK: begin
          if (fc_inc == CHECK_BYTES) begin
            field_count_next = '0;
            phase_next       = PH_PAYLOAD;
          end else begin
            field_count_next = fc_inc;
          end
        end
        PH_PAYLOAD: begin
          // A bad length drops the first byte after the header and resyncs.
          if (length_bad || remaining == '0) begin
            phase_next = PH_WAIT_START;
          end else begin
            if (idx == 10'd1) begin
              command_reg_next = rx_byte;
            end
            remaining_next            = rem_dec;
            result.push               = 1'b1;
            result.data.kind          = KIND_PAYLOAD;
            result.data.payload_index = idx;
            result.data.payload_byte  = rx_byte;
            result.data.last_payload  = (rem_dec == '0);
            if (rem_dec == '0) begin
              field_count_next = '0;
              phase_next       = PH_TRAILER;
            end
          end
        end
        PH_TRAILER: begin
          if (fc_inc == CHECK_BYTES) begin
            field_count_next           = '0;
            phase_next                 = PH_WAIT_START;
            result.push                = 1'b1;
            result.data.kind           = KIND_DONE;
            result.data.command_id     = command_reg;
            result.data.payload_length = frame_length;
          end else begin
            field_count_next = fc_inc;
          end
        end
        default: begin
          phase_next = PH_WAIT_START;
        end
      endcase
    end
  end

  a_bad_len_zero: assert property (@(posedge clk) disable iff (rst)
    length_bad |-> (frame_length == '0) && (remaining == '0))
    else $error("bad length must leave no payload to stream");

  a_done_after_trailer: assert property (@(posedge clk) disable iff (rst)
    result.push && result.data.kind == KIND_DONE |=> phase == PH_WAIT_START)
    else $error("frame done must return to start search");

  a_remaining_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= frame_length)
    else $error("remaining count exceeds frame length");

endmodule

`default_nettype wire

// ===== rtl/core/sfd_out_buf.sv =====
`default_nettype none

module sfd_out_buf
  import sfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sfd_push_t  wr,
  output logic            space,
  sfd_res_if.source       res
);

  sfd_result_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  // Two entries let the parser keep taking bytes while one result waits.
  assign space = (count != 2'd2);
  assign pop   = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr.push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      entry[wr_ptr] <= wr.data;
    end
  end

  assign res.valid          = (count != 2'd0);
  assign res.kind           = entry[rd_ptr].kind;
  assign res.payload_index  = entry[rd_ptr].payload_index;
  assign res.payload_byte   = entry[rd_ptr].payload_byte;
  assign res.last_payload   = entry[rd_ptr].last_payload;
  assign res.command_id     = entry[rd_ptr].command_id;
  assign res.payload_length = entry[rd_ptr].payload_length;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> space)
    else $error("result written into a full buffer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("buffer pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_deframer_unit.sv =====
`default_nettype none

// Channel  Dir  Handshake    Payload
// rx       in   valid/ready  rx_byte
// res      out  valid/ready  kind, payload_index, payload_byte, last_payload,
//                            command_id, payload_length
//
// One byte is taken per clock while rx.ready is high; each request is parsed in the cycle it is accepted.
// A result is registered into the output buffer and appears on res once it reaches the buffer head.
// Results wait in a two-entry buffer, so rx stays ready while one result stalls;
// rx.ready drops only when both entries are held.
// rst is synchronous and active high; it returns the parser to start-byte search.

module serial_frame_deframer_unit
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sfd_rx_if.sink    rx,
  sfd_res_if.source res
);

  logic      space;
  logic      accept;
  sfd_push_t result;

  assign rx.ready = space;
  assign accept   = rx.valid && space;

  sfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .result  (result)
  );

  sfd_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .wr    (result),
    .space (space),
    .res   (res)
  );

endmodule

`default_nettype wire
